@@ sv/erscu_pkg.sv @@
`default_nettype none

package erscu_pkg;

    localparam int unsigned DATA_W        = 8;
    localparam int unsigned LEN_W         = 32;
    localparam int unsigned ERR_W         = 3;
    localparam int unsigned QUEUE_DEPTH   = 2;
    localparam int unsigned QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DATA_W-1:0] TYPE_FEED   = 8'd1;
    localparam logic [DATA_W-1:0] TYPE_DIM    = 8'd2;
    localparam logic [DATA_W-1:0] TYPE_SCROLL = 8'd3;
    localparam logic [DATA_W-1:0] TYPE_EMPTY4 = 8'd4;
    localparam logic [DATA_W-1:0] TYPE_EMPTY5 = 8'd5;
    localparam logic [DATA_W-1:0] TYPE_EMPTY6 = 8'd6;

    localparam logic [LEN_W-1:0] DIM_PAYLOAD    = 32'd8;
    localparam logic [LEN_W-1:0] SCROLL_PAYLOAD = 32'd4;

    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_SHORT_HDR = 3'd1;
    localparam logic [ERR_W-1:0] ERR_SHORT_PAY = 3'd2;
    localparam logic [ERR_W-1:0] ERR_BAD_TYPE  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_BAD_LEN   = 3'd4;
    localparam logic [ERR_W-1:0] ERR_ZERO_DIM  = 3'd5;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              byte_present;
        logic              end_of_stream;
        logic              byte_nonzero;
    } item_t;

    function automatic logic [ERR_W-1:0] header_verdict(
        input logic [DATA_W-1:0] rec_type,
        input logic [LEN_W-1:0]  len
    );
        logic [ERR_W-1:0] v;
        case (rec_type)
            TYPE_FEED:   v = ERR_NONE;
            TYPE_DIM:    v = (len == DIM_PAYLOAD) ? ERR_NONE : ERR_BAD_LEN;
            TYPE_SCROLL: v = (len == SCROLL_PAYLOAD) ? ERR_NONE : ERR_BAD_LEN;
            TYPE_EMPTY4,
            TYPE_EMPTY5,
            TYPE_EMPTY6: v = (len == '0) ? ERR_NONE : ERR_BAD_LEN;
            default:     v = ERR_BAD_TYPE;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ sv/erscu_front.sv @@
`default_nettype none

module erscu_front
(
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [erscu_pkg::DATA_W-1:0]      s_axis_tdata,
    input  wire logic                              s_axis_tuser,
    input  wire logic                              s_axis_tlast,
    input  wire logic                              queue_full,
    output logic                                   push,
    output erscu_pkg::item_t                       push_item
);

    // beats carrying neither a byte nor an end are dropped here
    assign s_axis_tready = !queue_full;
    assign push = s_axis_tvalid && !queue_full && (s_axis_tuser || s_axis_tlast);

    always_comb
    begin
        push_item.data_byte     = s_axis_tdata;
        push_item.byte_present  = s_axis_tuser;
        push_item.end_of_stream = s_axis_tlast;
        push_item.byte_nonzero  = (s_axis_tdata != '0);
    end

endmodule

`default_nettype wire

@@ sv/erscu_queue.sv @@
`default_nettype none

module erscu_queue
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire erscu_pkg::item_t  push_item,
    output logic                   full,
    input  wire logic              pop,
    output logic                   pop_valid,
    output erscu_pkg::item_t       pop_item
);

    erscu_pkg::item_t                       entry_reg [erscu_pkg::QUEUE_DEPTH];
    logic [erscu_pkg::QUEUE_PTR_W-1:0]      wr_ptr_reg;
    logic [erscu_pkg::QUEUE_PTR_W-1:0]      rd_ptr_reg;
    logic [erscu_pkg::QUEUE_CNT_W-1:0]      count_reg;
    logic [erscu_pkg::QUEUE_PTR_W-1:0]      wr_ptr_next;
    logic [erscu_pkg::QUEUE_PTR_W-1:0]      rd_ptr_next;
    logic [erscu_pkg::QUEUE_CNT_W-1:0]      count_next;
    logic                                   do_pop;

    localparam logic [erscu_pkg::QUEUE_CNT_W-1:0] DEPTH_CNT =
        erscu_pkg::QUEUE_CNT_W'(erscu_pkg::QUEUE_DEPTH);
    localparam logic [erscu_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
        erscu_pkg::QUEUE_PTR_W'(erscu_pkg::QUEUE_DEPTH - 1);

    assign full      = (count_reg == DEPTH_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ sv/erscu_core.sv @@
`default_nettype none

module erscu_core
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire erscu_pkg::item_t  item,
    output logic                   item_take,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [7:0]             m_axis_tdata  // [0] stream_valid, [3:1] error_kind
);

    typedef enum logic [1:0]
    {
        PH_TYPE,
        PH_LEN,
        PH_PAYLOAD,
        PH_DEAD
    } phase_t;

    phase_t                              phase_reg, phase_next;
    logic [1:0]                          len_cnt_reg, len_cnt_next;
    logic [erscu_pkg::DATA_W-1:0]        record_type_reg, record_type_next;
    logic [erscu_pkg::LEN_W-1:0]         length_accum_reg, length_accum_next;
    logic [erscu_pkg::LEN_W-1:0]         payload_left_reg, payload_left_next;
    logic [2:0]                          payload_index_reg, payload_index_next;
    logic                                word_nonzero_reg, word_nonzero_next;
    logic [erscu_pkg::ERR_W-1:0]         error_code_reg, error_code_next;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic [7:0]                          m_tdata_reg, m_tdata_next;

    logic [erscu_pkg::LEN_W-1:0]         len_full;
    logic                                dim_record;
    logic                                fin_req;
    logic [erscu_pkg::ERR_W-1:0]         fin_hdr;
    logic [erscu_pkg::ERR_W-1:0]         fin_err;
    logic [erscu_pkg::ERR_W-1:0]         fin_v;
    logic [erscu_pkg::ERR_W-1:0]         err_tmp;
    logic                                wnz_tmp;
    logic [erscu_pkg::ERR_W-1:0]         kind;

    // an end beat needs the output slot, other beats never stall
    assign item_take = item_valid
        && (!item.end_of_stream || !m_tvalid_reg || m_axis_tready);

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    // length arrives little-endian, shifted in from the top
    assign len_full   = {item.data_byte, length_accum_reg[erscu_pkg::LEN_W-1:8]};
    assign dim_record = (record_type_reg == erscu_pkg::TYPE_DIM)
        && (length_accum_reg == erscu_pkg::DIM_PAYLOAD);

    always_comb
    begin
        phase_next         = phase_reg;
        len_cnt_next       = len_cnt_reg;
        record_type_next   = record_type_reg;
        length_accum_next  = length_accum_reg;
        payload_left_next  = payload_left_reg;
        payload_index_next = payload_index_reg;
        word_nonzero_next  = word_nonzero_reg;
        error_code_next    = error_code_reg;
        m_tvalid_next      = m_tvalid_reg && !m_axis_tready;
        m_tdata_next       = m_tdata_reg;
        fin_req            = 1'b0;
        fin_hdr            = erscu_pkg::ERR_NONE;
        fin_err            = error_code_reg;
        fin_v              = erscu_pkg::ERR_NONE;
        err_tmp            = error_code_reg;
        wnz_tmp            = word_nonzero_reg;
        kind               = erscu_pkg::ERR_NONE;

        if (item_take && item.byte_present)
        begin
            case (phase_reg)
                PH_TYPE:
                begin
                    record_type_next  = item.data_byte;
                    length_accum_next = '0;
                    len_cnt_next      = '0;
                    phase_next        = PH_LEN;
                end
                PH_LEN:
                begin
                    length_accum_next = len_full;
                    if (len_cnt_reg != 2'd3)
                    begin
                        len_cnt_next = len_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        payload_left_next  = len_full;
                        payload_index_next = '0;
                        word_nonzero_next  = 1'b0;
                        if (len_full == '0)
                        begin
                            fin_req = 1'b1;
                            fin_hdr = erscu_pkg::header_verdict(record_type_reg, len_full);
                            fin_err = error_code_reg;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    if (dim_record)
                    begin
                        wnz_tmp = word_nonzero_reg || item.byte_nonzero;
                        if (payload_index_reg[1:0] == 2'd3)
                        begin
                            if (!wnz_tmp)
                            begin
                                err_tmp = erscu_pkg::ERR_ZERO_DIM;
                            end
                            word_nonzero_next = 1'b0;
                        end
                        else
                        begin
                            word_nonzero_next = wnz_tmp;
                        end
                        payload_index_next = payload_index_reg + 1'b1;
                    end
                    error_code_next   = err_tmp;
                    payload_left_next = payload_left_reg - 1'b1;
                    if (payload_left_reg == {{(erscu_pkg::LEN_W-1){1'b0}}, 1'b1})
                    begin
                        fin_req = 1'b1;
                        fin_hdr = erscu_pkg::header_verdict(record_type_reg,
                                                            length_accum_reg);
                        fin_err = err_tmp;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (fin_req)
        begin
            fin_v = (fin_hdr == erscu_pkg::ERR_NONE) ? fin_err : fin_hdr;
            if (fin_v != erscu_pkg::ERR_NONE)
            begin
                error_code_next = fin_v;
                phase_next      = PH_DEAD;
            end
            else
            begin
                phase_next = PH_TYPE;
            end
        end

        if (item_take && item.end_of_stream)
        begin
            case (phase_next)
                PH_DEAD:    kind = error_code_next;
                PH_TYPE:    kind = erscu_pkg::ERR_NONE;
                PH_PAYLOAD: kind = erscu_pkg::ERR_SHORT_PAY;
                default:    kind = erscu_pkg::ERR_SHORT_HDR;
            endcase
            m_tvalid_next      = 1'b1;
            m_tdata_next       = {4'b0000, kind, kind == erscu_pkg::ERR_NONE};
            phase_next         = PH_TYPE;
            len_cnt_next       = '0;
            record_type_next   = '0;
            length_accum_next  = '0;
            payload_left_next  = '0;
            payload_index_next = '0;
            word_nonzero_next  = 1'b0;
            error_code_next    = erscu_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_TYPE;
            len_cnt_reg       <= '0;
            record_type_reg   <= '0;
            length_accum_reg  <= '0;
            payload_left_reg  <= '0;
            payload_index_reg <= '0;
            word_nonzero_reg  <= 1'b0;
            error_code_reg    <= erscu_pkg::ERR_NONE;
            m_tvalid_reg      <= 1'b0;
            m_tdata_reg       <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            len_cnt_reg       <= len_cnt_next;
            record_type_reg   <= record_type_next;
            length_accum_reg  <= length_accum_next;
            payload_left_reg  <= payload_left_next;
            payload_index_reg <= payload_index_next;
            word_nonzero_reg  <= word_nonzero_next;
            error_code_reg    <= error_code_next;
            m_tvalid_reg      <= m_tvalid_next;
            m_tdata_reg       <= m_tdata_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/event_record_stream_checker_unit.sv @@
// Checks a byte stream of type-length-value event records (type byte, 4-byte
// little-endian length, payload) and gives one verdict beat per stream, on the
// input beat with tlast set: tdata[0] is 1 for a well formed stream and
// tdata[3:1] the error kind (0 none, 1 short header, 2 short payload, 3 bad
// type, 4 bad length, 5 zero dimension). tuser marks a beat that carries a
// byte; a beat with tlast and no byte just ends the stream. The block takes one
// beat per clock: a two-entry queue feeds a checker that updates its counters
// on each byte, so the only stall is a verdict waiting on an output register
// that is still full. An end beat passes the queue, then that output register.
`default_nettype none

module event_record_stream_checker_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_axis_tuser,   // [0] byte_present
    input  wire logic        s_axis_tlast,   // end_of_stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata    // [0] stream_valid, [3:1] error_kind
);

    logic              queue_full;
    logic              push;
    erscu_pkg::item_t  push_item;
    logic              pop_valid;
    erscu_pkg::item_t  pop_item;
    logic              item_take;

    erscu_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser[0]),
        .s_axis_tlast  (s_axis_tlast),
        .queue_full    (queue_full),
        .push          (push),
        .push_item     (push_item)
    );

    erscu_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (item_take),
        .pop_valid (pop_valid),
        .pop_item  (pop_item)
    );

    erscu_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (pop_valid),
        .item          (pop_item),
        .item_take     (item_take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

@@ dv/event_record_stream_checker_unit_tb.sv @@
`default_nettype none

module event_record_stream_checker_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        PH_TYPE,
        PH_LEN0,
        PH_LEN1,
        PH_LEN2,
        PH_LEN3,
        PH_PAYLOAD,
        PH_DEAD
    } parse_phase_t;

    typedef struct packed {
        logic [erscu_pkg::ERR_W-1:0] error_kind;
        logic                        stream_valid;
    } stream_verdict_t;

    typedef struct {
        logic [7:0] data;
        logic       present;
        logic       last;
        bit         pause;
    } stim_beat_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic [0:0] s_axis_tuser = '0;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;

    stim_beat_t      pending_beats[$];
    stream_verdict_t expected_verdicts[$];
    logic [7:0]      strm[$];

    // predictor state
    parse_phase_t                ph = PH_TYPE;
    logic [7:0]                  rec_type = '0;
    logic [erscu_pkg::LEN_W-1:0] len_acc = '0;
    logic [erscu_pkg::LEN_W-1:0] pay_left = '0;
    logic [2:0]                  pay_idx = '0;
    logic                        word_nz = 1'b0;
    logic [erscu_pkg::ERR_W-1:0] err_latched = erscu_pkg::ERR_NONE;

    int  fail_count = 0;
    int  in_count = 0;
    int  beats_total = 0;
    int  stream_items = 0;
    bit  beat_taken = 1'b0;
    bit  paused_once = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;
    logic quiet;

    assign quiet = (in_count >= 600) && (in_count < 900);

    event_record_stream_checker_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic note_failure(input string msg);
        $display("ERROR %0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic clear_parser();
        ph = PH_TYPE;
        rec_type = '0;
        len_acc = '0;
        pay_left = '0;
        pay_idx = '0;
        word_nz = 1'b0;
        err_latched = erscu_pkg::ERR_NONE;
    endtask

    // whole record in: latch a type or length fault, or a zero word
    task automatic close_record();
        logic [erscu_pkg::ERR_W-1:0] v;
        case (rec_type)
            erscu_pkg::TYPE_FEED:
                v = erscu_pkg::ERR_NONE;
            erscu_pkg::TYPE_DIM:
                v = (len_acc == erscu_pkg::DIM_PAYLOAD) ? erscu_pkg::ERR_NONE
                                                        : erscu_pkg::ERR_BAD_LEN;
            erscu_pkg::TYPE_SCROLL:
                v = (len_acc == erscu_pkg::SCROLL_PAYLOAD) ? erscu_pkg::ERR_NONE
                                                           : erscu_pkg::ERR_BAD_LEN;
            erscu_pkg::TYPE_EMPTY4,
            erscu_pkg::TYPE_EMPTY5,
            erscu_pkg::TYPE_EMPTY6:
                v = (len_acc == '0) ? erscu_pkg::ERR_NONE : erscu_pkg::ERR_BAD_LEN;
            default:
                v = erscu_pkg::ERR_BAD_TYPE;
        endcase
        if (v == erscu_pkg::ERR_NONE)
            v = err_latched;
        if (v != erscu_pkg::ERR_NONE)
        begin
            err_latched = v;
            ph = PH_DEAD;
        end
        else
            ph = PH_TYPE;
    endtask

    task automatic advance_parser(input logic [7:0] b, input logic has_byte,
                                  input logic is_end);
        logic [erscu_pkg::ERR_W-1:0] kind;
        stream_verdict_t             v;
        if (has_byte)
        begin
            case (ph)
                PH_TYPE:
                begin
                    rec_type = b;
                    len_acc = '0;
                    ph = PH_LEN0;
                end
                PH_LEN0, PH_LEN1, PH_LEN2:
                begin
                    len_acc[8*(ph-PH_LEN0) +: 8] = b;
                    ph = parse_phase_t'(ph + 1);
                end
                PH_LEN3:
                begin
                    len_acc[31:24] = b;
                    pay_left = len_acc;
                    pay_idx = '0;
                    word_nz = 1'b0;
                    if (pay_left == '0)
                        close_record();
                    else
                        ph = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    if (rec_type == erscu_pkg::TYPE_DIM && len_acc == erscu_pkg::DIM_PAYLOAD)
                    begin
                        if (b != 8'h00)
                            word_nz = 1'b1;
                        if (pay_idx[1:0] == 2'd3)
                        begin
                            if (!word_nz)
                                err_latched = erscu_pkg::ERR_ZERO_DIM;
                            word_nz = 1'b0;
                        end
                        pay_idx = pay_idx + 3'd1;
                    end
                    pay_left = pay_left - 1;
                    if (pay_left == '0)
                        close_record();
                end
                default:
                    ;
            endcase
        end
        if (is_end)
        begin
            case (ph)
                PH_DEAD:    kind = err_latched;
                PH_TYPE:    kind = erscu_pkg::ERR_NONE;
                PH_PAYLOAD: kind = erscu_pkg::ERR_SHORT_PAY;
                default:    kind = erscu_pkg::ERR_SHORT_HDR;
            endcase
            v.stream_valid = (kind == erscu_pkg::ERR_NONE);
            v.error_kind = kind;
            expected_verdicts.push_back(v);
            clear_parser();
        end
    endtask

    // one record appended to strm, mostly well formed
    task automatic add_record();
        int          sel;
        int          n;
        logic [7:0]  typ;
        logic [31:0] len;
        logic [31:0] w;
        sel = $urandom_range(99);
        if (sel < 25)
        begin
            typ = erscu_pkg::TYPE_FEED;
            len = $urandom_range(12);
        end
        else if (sel < 45)
        begin
            typ = erscu_pkg::TYPE_DIM;
            len = erscu_pkg::DIM_PAYLOAD;
        end
        else if (sel < 60)
        begin
            typ = erscu_pkg::TYPE_SCROLL;
            len = erscu_pkg::SCROLL_PAYLOAD;
        end
        else if (sel < 80)
        begin
            typ = 8'($urandom_range(4, 6));
            len = '0;
        end
        else
        begin
            typ = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
            len = ($urandom_range(3) == 0) ? 32'($urandom) : 32'($urandom_range(9));
        end
        strm.push_back(typ);
        for (int k = 0; k < 4; k++)
            strm.push_back(len[8*k +: 8]);
        if (typ == erscu_pkg::TYPE_DIM && len == erscu_pkg::DIM_PAYLOAD)
        begin
            for (int k = 0; k < 2; k++)
            begin
                case ($urandom_range(9))
                    0: w = '0;
                    1, 2: w = 32'($urandom_range(1, 255)) << (8 * $urandom_range(3));
                    default:
                    begin
                        w = $urandom;
                        if (w == '0)
                            w = 32'd1;
                    end
                endcase
                for (int j = 0; j < 4; j++)
                    strm.push_back(w[8*j +: 8]);
            end
        end
        else
        begin
            n = (len > 32'd16) ? int'($urandom_range(16)) : int'(len);
            repeat (n)
                strm.push_back(8'($urandom));
        end
    endtask

    task automatic flush_stream(input bit end_on_byte, input bit pause, input bit noisy);
        bit         p;
        stim_beat_t sb;
        p = pause;
        if (strm.size() == 0)
            end_on_byte = 1'b0;
        for (int i = 0; i < strm.size(); i++)
        begin
            if (noisy && $urandom_range(24) == 0)
            begin
                sb = '{8'($urandom), 1'b0, 1'b0, p};
                p = 1'b0;
                pending_beats.push_back(sb);
            end
            sb = '{strm[i], 1'b1, end_on_byte && (i == strm.size() - 1), p};
            p = 1'b0;
            pending_beats.push_back(sb);
            stream_items++;
        end
        if (!end_on_byte)
        begin
            sb = '{8'($urandom), 1'b0, 1'b1, p};
            pending_beats.push_back(sb);
            stream_items++;
        end
        strm.delete();
    endtask

    // monitor: verdict check first, then predictor on the input beat
    always @(posedge clk)
    begin
        stream_verdict_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_verdicts.size() == 0)
                    note_failure($sformatf("verdict beat %h with none pending", m_axis_tdata));
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (m_axis_tdata[0] !== want.stream_valid)
                        note_failure($sformatf("stream_valid got %b want %b",
                                               m_axis_tdata[0], want.stream_valid));
                    if (m_axis_tdata[3:1] !== want.error_kind)
                        note_failure($sformatf("error_kind got %0d want %0d",
                                               m_axis_tdata[3:1], want.error_kind));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                advance_parser(s_axis_tdata, s_axis_tuser[0], s_axis_tlast);
                in_count++;
                beat_taken = 1'b1;
            end
        end
    end

    // driver
    always @(negedge clk)
    begin
        stim_beat_t nb;
        if (rst_n && (!s_axis_tvalid || beat_taken))
        begin
            beat_taken = 1'b0;
            if (pending_beats.size() != 0
                && !(pending_beats[0].pause && expected_verdicts.size() != 0)
                && (quiet || $urandom_range(99) >= 8))
            begin
                nb = pending_beats.pop_front();
                s_axis_tdata <= nb.data;
                s_axis_tuser <= nb.present;
                s_axis_tlast <= nb.last;
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver, with one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!hold_done && in_count >= 300)
        begin
            hold_done <= 1'b1;
            hold_left <= 400;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= quiet || ($urandom_range(99) >= 8);
    end

    initial
    begin
        #3ms;
        $display("event_record_stream_checker_unit regression: fail");
        $finish;
    end

    initial
    begin
        int cut;
        // empty stream
        flush_stream(1'b0, 1'b0, 1'b0);
        // type 2 with a zero first word
        strm = '{8'h02, 8'h08, 8'h00, 8'h00, 8'h00,
                 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff};
        flush_stream(1'b1, 1'b0, 1'b0);
        // bad type, then a byte that is ignored after the error
        strm = '{8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03};
        flush_stream(1'b1, 1'b0, 1'b0);
        // cut inside the header
        strm = '{8'h03, 8'h05};
        flush_stream(1'b1, 1'b0, 1'b0);
        // cut payload wins over a bad type
        strm = '{8'h09, 8'h01, 8'h00, 8'h00, 8'h00};
        flush_stream(1'b0, 1'b0, 1'b0);

        while (stream_items < 1430)
        begin
            repeat ($urandom_range(4))
                add_record();
            if (strm.size() != 0 && $urandom_range(7) == 0)
            begin
                cut = $urandom_range(1, (strm.size() < 6) ? strm.size() : 6);
                repeat (cut)
                    void'(strm.pop_back());
            end
            flush_stream(1'($urandom_range(1)), !paused_once && stream_items > 1000, 1'b1);
            if (stream_items > 1000)
                paused_once = 1'b1;
        end
        beats_total = pending_beats.size();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (in_count < beats_total)
            @(posedge clk);
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("event_record_stream_checker_unit regression: pass");
        else
            $display("event_record_stream_checker_unit regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
